// ===== rtl/core/huffman_encoded_length_macros.svh =====
// Assertion macros shared by the huffman_encoded_length RTL.
`ifndef HUFFMAN_ENCODED_LENGTH_MACROS_SVH
`define HUFFMAN_ENCODED_LENGTH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HEL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in huffman_encoded_length");

// Next-cycle implication, disabled while reset is high.
`define HEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in huffman_encoded_length");

`endif

// ===== rtl/core/hel_pkg.sv =====
`default_nettype none
package hel_pkg;

   localparam int SYMBOLS_DEF    = 26;
   localparam int COUNT_BITS_DEF = 24;
   localparam int CODE_BITS      = 7;
   localparam int SUM_BITS       = 29;

   localparam logic [CODE_BITS-1:0] FIRST_CODE = 7'd97;
   localparam logic [SUM_BITS-1:0]  SUM_MAX    = {SUM_BITS{1'b1}};

   // One slot of the sorted weight queue.
   typedef struct packed {
      logic                valid;
      logic [SUM_BITS-1:0] weight;
   } slot_type;

   typedef enum logic [1:0] {
      QOP_HOLD,
      QOP_INSERT,
      QOP_SHIFT2,
      QOP_CLEAR
   } qop_type;

   typedef struct packed {
      qop_type             op;
      logic [SUM_BITS-1:0] weight;
   } qctl_type;

   typedef struct packed {
      logic                 en;
      logic [CODE_BITS-1:0] offset;
      logic                 shift;
   } cctl_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hel_channels.sv =====
`default_nettype none
interface hel_req_if;
   logic                          valid;
   logic                          ready;
   logic [hel_pkg::CODE_BITS-1:0] letter_code;
   logic                          last_letter;
   modport source (output valid, output letter_code, output last_letter, input ready);
   modport sink (input valid, input letter_code, input last_letter, output ready);
endinterface

interface hel_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hel_pkg::SUM_BITS-1:0] total_bits;
   logic                         count_overflow;
   modport source (output valid, output total_bits, output count_overflow, input ready);
   modport sink (input valid, input total_bits, input count_overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hel_count_cell.sv =====
`default_nettype none
module hel_count_cell #(
   parameter int COUNT_BITS = 24,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hel_pkg::cctl_type     ctl,
   input  wire logic [COUNT_BITS-1:0] next_count,
   output logic      [COUNT_BITS-1:0] count,
   output logic                       sat_hit
);
   import hel_pkg::*;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  bump, at_max;

   assign bump    = ctl.en && (32'(ctl.offset) == 32'(INDEX));
   assign at_max  = (count_ff == {COUNT_BITS{1'b1}});
   assign sat_hit = bump && at_max;
   assign count   = count_ff;

   // During the drain the counts move one cell toward the head each cycle.
   always_comb begin
      count_in = count_ff;
      if (ctl.shift) begin
         count_in = next_count;
      end else if (bump && !at_max) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/hel_queue_cell.sv =====
`default_nettype none
module hel_queue_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hel_pkg::qctl_type ctl,
   input  wire hel_pkg::slot_type prev_slot,
   input  wire logic              prev_keep,
   input  wire hel_pkg::slot_type next2_slot,
   output hel_pkg::slot_type      slot,
   output logic                   keep
);
   import hel_pkg::*;

   slot_type slot_ff, slot_in;

   // An empty slot counts as larger than any weight.
   assign keep = slot_ff.valid && (slot_ff.weight <= ctl.weight);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      case (ctl.op)
         QOP_INSERT: begin
            if (!keep) begin
               slot_in = prev_keep ? slot_type'{valid: 1'b1, weight: ctl.weight} : prev_slot;
            end
         end
         QOP_SHIFT2: slot_in = next2_slot;
         QOP_CLEAR:  slot_in = '0;
         default:    slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/huffman_encoded_length.sv =====
`default_nettype none
`include "huffman_encoded_length_macros.svh"
// Huffman encoded length of a string of lower-case letters. Letters enter as
// req_if beats, one per cycle while the block is counting; each letter bumps
// its own count cell, and a count that would pass its maximum stays there and
// sets the overflow flag. The beat marked last_letter is counted too and ends
// the string. The block then stops taking beats and works in steps: the
// count cells shift their counts one per cycle into a sorted chain of queue
// cells (the drain, which also clears the counts), then each merge takes the
// two smallest weights off the head of that chain in S_POP and inserts their
// sum back in S_PUSH, until S_POP finds a single weight left, and S_DONE
// hands the result to the output register. The sum of all merged weights,
// which is the encoded length in bits, appears on rsp_if together with the
// overflow flag. A string of one distinct letter, or with no letter in range,
// gives 0. Codes outside 'a' to 'z' are ignored but a last mark on them still
// ends the string. A finished result waits in an output register, so the next
// string can be counted while it is not yet taken; if that string also
// finishes first, the block holds in S_DONE until the earlier result beat is
// taken.
module huffman_encoded_length #(
   parameter int SYMBOLS    = hel_pkg::SYMBOLS_DEF,
   parameter int COUNT_BITS = hel_pkg::COUNT_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   hel_req_if.sink   req_if,
   hel_rsp_if.source rsp_if
);
   import hel_pkg::*;

   localparam int IDX_BITS  = $clog2(SYMBOLS);
   localparam int SIZE_BITS = $clog2(SYMBOLS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DRAIN,
      S_POP,
      S_PUSH,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   drain_ff, drain_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [SUM_BITS-1:0]   w_ff, w_in;
   logic                  sat_ff, sat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]   rsp_bits_ff, rsp_bits_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  accept, in_range, any_sat, counts_nonzero, rsp_free;
   logic [CODE_BITS-1:0]  offset;
   cctl_type              cctl;
   qctl_type              qctl;
   logic [COUNT_BITS-1:0] counts [SYMBOLS];
   logic [SYMBOLS-1:0]    sat_hits, count_nz;
   slot_type              slots [SYMBOLS];
   logic [SYMBOLS-1:0]    keeps, qvalid;
   logic [32:0]           head_ext;
   logic [SUM_BITS-1:0]   head_w;

   // Input side: letters are taken only while counting.
   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign offset       = req_if.letter_code - FIRST_CODE;
   assign in_range     = (req_if.letter_code >= FIRST_CODE) &&
                         (32'(offset) < 32'(SYMBOLS));

   assign cctl.en     = accept && in_range;
   assign cctl.offset = offset;
   assign cctl.shift  = (state_ff == S_DRAIN);

   // Row of count cells; cell 0 is the head that feeds the queue.
   for (genvar i = 0; i < SYMBOLS; i++) begin : g_count
      logic [COUNT_BITS-1:0] nxt;
      if (i + 1 < SYMBOLS) begin : g_mid
         assign nxt = counts[i+1];
      end else begin : g_end
         assign nxt = '0;
      end
      hel_count_cell #(.COUNT_BITS(COUNT_BITS), .INDEX(i)) u_count (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cctl),
         .next_count (nxt),
         .count      (counts[i]),
         .sat_hit    (sat_hits[i])
      );
      assign count_nz[i] = (counts[i] != '0);
   end

   assign any_sat        = |sat_hits;
   assign counts_nonzero = |count_nz;

   // A count wider than the sum field is clamped to the sum maximum.
   assign head_ext = 33'(counts[0]);
   assign head_w   = (head_ext > 33'(SUM_MAX)) ? SUM_MAX : head_ext[SUM_BITS-1:0];

   // Sorted chain of queue cells, smallest weight at cell 0.
   for (genvar i = 0; i < SYMBOLS; i++) begin : g_queue
      slot_type prv, nx2;
      logic     pkeep;
      if (i > 0) begin : g_prev
         assign prv   = slots[i-1];
         assign pkeep = keeps[i-1];
      end else begin : g_head
         assign prv   = '0;
         assign pkeep = 1'b1;
      end
      if (i + 2 < SYMBOLS) begin : g_next
         assign nx2 = slots[i+2];
      end else begin : g_tail
         assign nx2 = '0;
      end
      hel_queue_cell u_queue (
         .clock      (clock),
         .reset      (reset),
         .ctl        (qctl),
         .prev_slot  (prv),
         .prev_keep  (pkeep),
         .next2_slot (nx2),
         .slot       (slots[i]),
         .keep       (keeps[i])
      );
      assign qvalid[i] = slots[i].valid;
   end

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      size_in      = size_ff;
      sum_in       = sum_ff;
      w_in         = w_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      qctl.op      = QOP_HOLD;
      qctl.weight  = w_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && any_sat) begin
               sat_in = 1'b1;
            end
            if (accept && req_if.last_letter) begin
               state_in = S_DRAIN;
               drain_in = '0;
               size_in  = '0;
               sum_in   = '0;
            end
         end
         S_DRAIN: begin
            // Zero counts are letters that never occurred and stay out.
            qctl.weight = head_w;
            if (counts[0] != '0) begin
               qctl.op = QOP_INSERT;
               size_in = size_ff + SIZE_BITS'(1);
            end
            drain_in = drain_ff + IDX_BITS'(1);
            if (drain_ff == IDX_BITS'(SYMBOLS - 1)) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (size_ff > SIZE_BITS'(1)) begin
               w_in     = sat_add(slots[0].weight, slots[1].weight);
               qctl.op  = QOP_SHIFT2;
               size_in  = size_ff - SIZE_BITS'(2);
               state_in = S_PUSH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PUSH: begin
            qctl.op  = QOP_INSERT;
            size_in  = size_ff + SIZE_BITS'(1);
            sum_in   = sat_add(sum_ff, w_ff);
            state_in = S_POP;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = sum_ff;
               rsp_ovf_in   = sat_ff;
               sat_in       = 1'b0;
               size_in      = '0;
               qctl.op      = QOP_CLEAR;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drain_ff     <= '0;
         size_ff      <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         size_ff      <= size_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff        <= w_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.total_bits     = rsp_bits_ff;
   assign rsp_if.count_overflow = rsp_ovf_ff;

   // The occupied queue cells always match the tracked queue size.
   `HEL_ASSERT_NOW(a_queue_size, clock, reset, 1'b1, $countones(qvalid) == 32'(size_ff))
   // The two weights merged are the two smallest, in order.
   `HEL_ASSERT_NOW(a_head_sorted, clock, reset,
                   (state_ff == S_POP) && (size_ff > SIZE_BITS'(1)),
                   slots[0].weight <= slots[1].weight)
   // The drain leaves every count cell cleared for the next string.
   `HEL_ASSERT_NOW(a_counts_cleared, clock, reset,
                   (state_ff == S_POP) || (state_ff == S_PUSH) || (state_ff == S_DONE),
                   !counts_nonzero)
   // A finished string always produces a result beat.
   `HEL_ASSERT_NEXT(a_result_out, clock, reset,
                    (state_ff == S_DONE) && rsp_free,
                    rsp_valid_ff && (state_ff == S_IDLE))
endmodule
`default_nettype wire

// ===== tb/hel_length_checker.sv =====
`default_nettype none
// Watches the letter and result channels, keeps its own letter histogram and
// predicts the encoded length of every finished string.
module hel_length_checker (
   input  wire logic clock,
   input  wire logic reset,
   hel_req_if        req_if,
   hel_rsp_if        rsp_if,
   output int        error_count,
   output int        lengths_pending,
   output int        letters_seen,
   output int        strings_seen
);
   import hel_pkg::*;

   localparam int ALPHABET = 26;
   localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;

   typedef struct packed {
      logic [SUM_BITS-1:0] total_bits;
      logic                count_overflow;
   } length_type;

   logic [23:0] letter_tally [ALPHABET];
   logic        tally_saturated;
   length_type  expected_lengths [$];

   function automatic logic [SUM_BITS-1:0] add_clamped(input logic [SUM_BITS-1:0] a,
                                                      input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   // Repeatedly merges the two lightest weights; the sum of the merges does
   // not depend on how ties are broken.
   function automatic logic [SUM_BITS-1:0] encoded_bits(input logic [23:0] tally [ALPHABET]);
      logic [SUM_BITS-1:0] weights [ALPHABET];
      logic [SUM_BITS-1:0] merged;
      logic [SUM_BITS-1:0] total;
      int n, lo, nx;
      n = 0;
      total = '0;
      for (int i = 0; i < ALPHABET; i++) begin
         if (tally[i] != 0) begin
            weights[n] = SUM_BITS'(tally[i]);
            n++;
         end
      end
      while (n > 1) begin
         lo = 0;
         for (int i = 1; i < n; i++) if (weights[i] < weights[lo]) lo = i;
         merged = weights[lo];
         weights[lo] = weights[n-1];
         n--;
         nx = 0;
         for (int i = 1; i < n; i++) if (weights[i] < weights[nx]) nx = i;
         merged = add_clamped(merged, weights[nx]);
         weights[nx] = merged;
         total = add_clamped(total, merged);
      end
      return total;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      length_type want;
      int idx;
      if (reset) begin
         foreach (letter_tally[i]) letter_tally[i] = '0;
         tally_saturated = 1'b0;
         expected_lengths.delete();
         error_count = 0;
         letters_seen = 0;
         strings_seen = 0;
         lengths_pending = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            letters_seen++;
            idx = int'(req_if.letter_code) - int'(FIRST_CODE);
            if (idx >= 0 && idx < ALPHABET) begin
               if (letter_tally[idx] == COUNT_TOP) tally_saturated = 1'b1;
               else letter_tally[idx] = letter_tally[idx] + 24'd1;
            end
            if (req_if.last_letter) begin
               strings_seen++;
               expected_lengths.push_back(length_type'{encoded_bits(letter_tally),
                                                       tally_saturated});
               foreach (letter_tally[i]) letter_tally[i] = '0;
               tally_saturated = 1'b0;
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_lengths.size() == 0) begin
               report_mismatch("unexpected beat, total_bits", 32'(rsp_if.total_bits), 0);
            end else begin
               want = expected_lengths.pop_front();
               if (rsp_if.total_bits !== want.total_bits)
                  report_mismatch("total_bits", 32'(rsp_if.total_bits),
                                  32'(want.total_bits));
               if (rsp_if.count_overflow !== want.count_overflow)
                  report_mismatch("count_overflow", 32'(rsp_if.count_overflow),
                                  32'(want.count_overflow));
            end
         end
         lengths_pending = expected_lengths.size();
      end
   end
endmodule
`default_nettype wire

// ===== tb/tb_huffman_encoded_length.sv =====
`default_nettype none
// Top of the bench: it drives strings of letters into the block, steers the
// result side's ready, and gives the verdict from the checker's error count and pending lengths.
module tb_huffman_encoded_length;
   import hel_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_BEATS = 380;

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   beats_sent;
   logic hold_request;
   logic hold_seen;
   int   hold_left;

   int error_count, lengths_pending, letters_seen, strings_seen;

   hel_req_if req_ch ();
   hel_rsp_if rsp_ch ();

   huffman_encoded_length DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   hel_length_checker length_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch),
      .error_count     (error_count),
      .lengths_pending (lengths_pending),
      .letters_seen    (letters_seen),
      .strings_seen    (strings_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is stopped if it ever takes far longer than the slowest
   // correct run could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result-side ready. A toggle of hold_request starts a long hold-off,
   // counted here, during which the block has to back up onto its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= 600;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one letter beat, after any random idle cycles, and returns once
   // it has been taken. Valid is left high so back-to-back beats need no
   // second assignment in the same step.
   task automatic send_letter(input logic [CODE_BITS-1:0] code, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.letter_code <= code;
      req_ch.last_letter <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
   endtask

   // A string over a random window of the alphabet, so that narrow windows
   // give single-letter strings. Some beats are random 7-bit noise codes.
   task automatic send_string(input int len, input int noise_pct);
      int first, span;
      logic [CODE_BITS-1:0] code;
      first = $urandom_range(25);
      span = $urandom_range(26 - first, 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct) code = CODE_BITS'($urandom_range(127));
         else code = CODE_BITS'(int'(FIRST_CODE) + first + $urandom_range(span - 1));
         send_letter(code, i == len - 1);
      end
   endtask

   task automatic random_phase(input int beats);
      int goal;
      goal = beats_sent + beats;
      while (beats_sent < goal) begin
         case ($urandom_range(9))
            0: send_letter(CODE_BITS'($urandom_range(127)), 1'b1);  // lone beat ends a string
            1: send_string($urandom_range(80, 20), 5);
            2: send_string($urandom_range(12, 1), 40);
            default: send_string($urandom_range(10, 1), 2);
         endcase
      end
   endtask

   initial begin
      cycle_count = 0;
      beats_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.letter_code <= '0;
      req_ch.last_letter <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings: an empty string ended by an out-of-range code, the
      // code edges just outside a..z, a single distinct letter, both ends of
      // the alphabet, and every letter once in one string.
      send_letter(7'd0, 1'b1);
      send_letter(7'd127, 1'b1);
      send_letter(7'd96, 1'b0);
      send_letter(7'd123, 1'b1);
      send_letter(7'd97, 1'b0);
      send_letter(7'd97, 1'b1);
      send_letter(7'd122, 1'b0);
      send_letter(7'd97, 1'b0);
      send_letter(7'd122, 1'b1);
      for (int i = 0; i < 26; i++) send_letter(CODE_BITS'(97 + i), i == 25);

      // Free-running phase, with one long hold-off on the result side while
      // letters keep coming.
      random_phase(PHASE_BEATS / 2);
      hold_request = ~hold_request;
      random_phase(PHASE_BEATS / 2);

      // Let everything drain before the sender goes quiet-heavy.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (lengths_pending != 0) @(posedge clock);

      send_idle_pct = 87;
      random_phase(PHASE_BEATS);
      send_idle_pct = 0;
      recv_stall_pct = 87;
      random_phase(PHASE_BEATS);
      send_idle_pct = 29;
      recv_stall_pct = 29;
      random_phase(PHASE_BEATS);
      recv_stall_pct = 0;
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (lengths_pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);

      $display("Covered %0d letter beats in %0d strings, with noise codes, single-letter",
               letters_seen, strings_seen);
      $display("and empty strings, under sender idling, result stalls and a long hold-off.");
      if (error_count == 0 && lengths_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
